// ----- src/wsts_pkg.sv -----
// ----------------------------------------------------------------------------
// wsts_pkg: shared types and constants of the WAVE stream parser
// Transaction structs for both channels, the queue entry and the code values.
// ----------------------------------------------------------------------------
`default_nettype none

package wsts_pkg;

   // One file byte and its end marker.
   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_file;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic [31:0]        rate_hz;
      logic [3:0]         status;
   } rsp_type;

   // Work handed from the parser to the sample decoder.
   typedef struct packed {
      logic        main_v;
      logic        main_info;
      logic [63:0] data;
      logic [1:0]  bps_m1;
      logic        is_float;
      logic        stereo;
      logic        stat_v;
      logic [3:0]  status;
   } entry_type;

   // Result kinds.
   localparam logic [1:0] KIND_FRAME  = 2'd0;
   localparam logic [1:0] KIND_INFO   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Status codes.
   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_TOO_SMALL = 4'd1;
   localparam logic [3:0] ST_BAD_MAGIC = 4'd2;
   localparam logic [3:0] ST_NO_FMT    = 4'd3;
   localparam logic [3:0] ST_NO_DATA   = 4'd4;
   localparam logic [3:0] ST_TAG       = 4'd5;
   localparam logic [3:0] ST_CHANNELS  = 4'd6;
   localparam logic [3:0] ST_BITS      = 4'd7;
   localparam logic [3:0] ST_ALIGN     = 4'd8;
   localparam logic [3:0] ST_TRUNCATED = 4'd9;

   // Chunk identifiers and format tags.
   localparam logic [31:0] TAG_FMT          = 32'h20746D66;
   localparam logic [31:0] TAG_DATA         = 32'h61746164;
   localparam logic [15:0] FMT_TAG_PCM      = 16'h0001;
   localparam logic [15:0] FMT_TAG_FLOAT    = 16'h0003;
   localparam logic [15:0] FMT_TAG_EXTENDED = 16'hFFFE;
   localparam logic [5:0]  MIN_FILE_BYTES   = 6'd44;

endpackage

`default_nettype wire

// ----- src/wsts_front.sv -----
// ----------------------------------------------------------------------------
// wsts_front: RIFF/WAVE chunk parser
// Walks the header and chunks one byte per cycle while the queue has room,
// and queues frames, format info and the final status for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module wsts_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire wsts_pkg::req_type   req_data,
   input  wire logic                q_full,
   output logic                     push,
   output wsts_pkg::entry_type      push_entry
);
   import wsts_pkg::*;

   typedef enum logic [6:0] {
      PH_HEAD = 7'b0000001,
      PH_CHDR = 7'b0000010,
      PH_FMT  = 7'b0000100,
      PH_DATA = 7'b0001000,
      PH_SKIP = 7'b0010000,
      PH_PAD  = 7'b0100000,
      PH_HALT = 7'b1000000
   } phase_type;

   localparam logic [7:0] MAGIC [12] = '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h57, 8'h41, 8'h56, 8'h45};

   logic        accept;
   logic [7:0]  b;
   logic [5:0]  cnt_ff, cnt_in;
   phase_type   phase_ff, phase_in;
   logic [31:0] tag_ff, tag_in, len_ff, len_in, left_ff, left_in;
   logic [15:0] fmt_tag_ff, fmt_tag_in, chans_ff, chans_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] stride_ff, stride_in, bits_ff, bits_in;
   logic        seen_fmt_ff, seen_fmt_in, seen_data_ff, seen_data_in;
   logic [15:0] fpos_ff, fpos_in;
   logic [63:0] fbytes_ff, fbytes_in;
   logic        ext_v_ff, ext_v_in;
   logic [7:0]  ext_lo_ff, ext_lo_in;
   logic [3:0]  err_ff, err_in;

   logic [31:0] tag_n, len_n, off;
   logic [63:0] fb_n;
   logic [15:0] fpos_n, align;
   logic [18:0] need;
   logic        bits_ok;
   logic [3:0]  sd_err;
   logic        main_v, main_info, stat_v;
   logic [63:0] main_data;
   logic [3:0]  stat_code;

   // The parser takes a byte whenever the queue has room.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign b         = req_data.byte_in;

   // Format checks made when a data chunk header completes.
   always_comb begin
      need    = {16'b0, bits_ff[5:3]} * {3'b0, chans_ff};
      align   = (stride_ff == 16'd0) ? need[15:0] : stride_ff;
      bits_ok = (bits_ff == 16'd8) || (bits_ff == 16'd16) ||
                (bits_ff == 16'd24) || (bits_ff == 16'd32);
      if (!seen_fmt_ff) begin
         sd_err = ST_NO_FMT;
      end else if (fmt_tag_ff != FMT_TAG_PCM && fmt_tag_ff != FMT_TAG_FLOAT) begin
         sd_err = ST_TAG;
      end else if (chans_ff == 16'd0) begin
         sd_err = ST_CHANNELS;
      end else if (!bits_ok) begin
         sd_err = ST_BITS;
      end else if ({3'b0, align} < need) begin
         sd_err = ST_ALIGN;
      end else begin
         sd_err = ST_OK;
      end
   end

   // Next state of the parser for one byte.
   always_comb begin
      cnt_in       = (cnt_ff == 6'h3F) ? cnt_ff : cnt_ff + 6'd1;
      phase_in     = phase_ff;
      tag_in       = tag_ff;
      len_in       = len_ff;
      left_in      = left_ff;
      fmt_tag_in   = fmt_tag_ff;
      chans_in     = chans_ff;
      rate_in      = rate_ff;
      stride_in    = stride_ff;
      bits_in      = bits_ff;
      seen_fmt_in  = seen_fmt_ff;
      seen_data_in = seen_data_ff;
      fpos_in      = fpos_ff;
      fbytes_in    = fbytes_ff;
      ext_v_in     = ext_v_ff;
      ext_lo_in    = ext_lo_ff;
      err_in       = err_ff;
      main_v       = 1'b0;
      main_info    = 1'b0;
      main_data    = '0;
      stat_v       = 1'b0;
      stat_code    = ST_OK;
      tag_n        = tag_ff;
      len_n        = len_ff;
      fb_n         = fbytes_ff;
      fpos_n       = fpos_ff + 16'd1;
      off          = len_ff - left_ff;

      unique case (phase_ff)
         PH_HEAD: begin
            if (cnt_ff < 6'd12 && (cnt_ff < 6'd4 || cnt_ff >= 6'd8) &&
                b != MAGIC[cnt_ff[3:0]]) begin
               err_in   = ST_BAD_MAGIC;
               phase_in = PH_HALT;
            end else if (cnt_ff >= 6'd11) begin
               phase_in = PH_CHDR;
               left_in  = '0;
            end
         end
         PH_CHDR: begin
            // Four tag bytes, then four little-endian length bytes.
            if (left_ff < 32'd4) begin
               tag_n = {b, tag_ff[31:8]};
               if (left_ff == 32'd0) begin
                  len_n = '0;
               end
            end else begin
               len_n[{left_ff[1:0], 3'b000} +: 8] = len_ff[{left_ff[1:0], 3'b000} +: 8] | b;
            end
            tag_in  = tag_n;
            len_in  = len_n;
            left_in = left_ff + 32'd1;
            if (left_ff[2:0] == 3'd7) begin
               left_in = '0;
               if (tag_n == TAG_FMT && len_n >= 32'd16) begin
                  left_in  = len_n;
                  ext_v_in = 1'b0;
                  phase_in = PH_FMT;
               end else if (tag_n == TAG_DATA && !seen_data_ff) begin
                  seen_data_in = 1'b1;
                  if (sd_err != ST_OK) begin
                     err_in = sd_err;
                     if (len_n == 32'd0) begin
                        phase_in = PH_CHDR;
                     end else begin
                        left_in  = len_n;
                        phase_in = PH_SKIP;
                     end
                  end else begin
                     stride_in = align;
                     fpos_in   = '0;
                     fbytes_in = '0;
                     main_v    = 1'b1;
                     main_info = 1'b1;
                     main_data = {32'b0, rate_ff};
                     if (len_n == 32'd0) begin
                        phase_in = PH_CHDR;
                     end else begin
                        left_in  = len_n;
                        phase_in = PH_DATA;
                     end
                  end
               end else if (len_n != 32'd0) begin
                  left_in  = len_n;
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_FMT: begin
            // Capture the fields by their offset inside the chunk.
            if (off < 32'd2) begin
               fmt_tag_in[{off[0], 3'b000} +: 8] = b;
            end else if (off < 32'd4) begin
               chans_in[{off[0], 3'b000} +: 8] = b;
            end else if (off < 32'd8) begin
               rate_in[{off[1:0], 3'b000} +: 8] = b;
            end else if (off == 32'd12 || off == 32'd13) begin
               stride_in[{off[0], 3'b000} +: 8] = b;
            end else if (off == 32'd14 || off == 32'd15) begin
               bits_in[{off[0], 3'b000} +: 8] = b;
            end else if (off == 32'd24) begin
               if (fmt_tag_ff == FMT_TAG_EXTENDED && len_ff >= 32'd40) begin
                  ext_v_in  = 1'b1;
                  ext_lo_in = b;
               end
            end else if (off == 32'd25) begin
               if (ext_v_ff) begin
                  fmt_tag_in = {b, ext_lo_ff};
               end
            end
            left_in = left_ff - 32'd1;
            if (left_ff == 32'd1) begin
               seen_fmt_in = 1'b1;
               ext_v_in    = 1'b0;
               left_in     = '0;
               phase_in    = len_ff[0] ? PH_PAD : PH_CHDR;
            end
         end
         PH_DATA: begin
            // Collect the first eight bytes of the frame.
            if (fpos_ff < 16'd8) begin
               fb_n[{fpos_ff[2:0], 3'b000} +: 8] = fbytes_ff[{fpos_ff[2:0], 3'b000} +: 8] | b;
            end
            if (fpos_n == stride_ff) begin
               main_v    = 1'b1;
               main_data = fb_n;
               fpos_in   = '0;
               fbytes_in = '0;
            end else begin
               fpos_in   = fpos_n;
               fbytes_in = fb_n;
            end
            left_in = left_ff - 32'd1;
            if (left_ff == 32'd1) begin
               fpos_in   = '0;
               fbytes_in = '0;
               left_in   = '0;
               phase_in  = len_ff[0] ? PH_PAD : PH_CHDR;
            end
         end
         PH_SKIP: begin
            left_in = left_ff - 32'd1;
            if (left_ff == 32'd1) begin
               phase_in = len_ff[0] ? PH_PAD : PH_CHDR;
            end
         end
         PH_PAD: begin
            phase_in = PH_CHDR;
            left_in  = '0;
         end
         PH_HALT: begin
            phase_in = PH_HALT;
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase

      // The final byte reports a status and returns the parser to reset.
      if (req_data.end_of_file) begin
         stat_v = 1'b1;
         if (cnt_in < MIN_FILE_BYTES) begin
            stat_code = ST_TOO_SMALL;
         end else if (err_in != ST_OK) begin
            stat_code = err_in;
         end else if (!seen_data_in) begin
            stat_code = seen_fmt_in ? ST_NO_DATA : ST_NO_FMT;
         end else if (phase_in == PH_DATA && left_in != 32'd0) begin
            stat_code = ST_TRUNCATED;
         end
         cnt_in       = '0;
         phase_in     = PH_HEAD;
         tag_in       = '0;
         len_in       = '0;
         left_in      = '0;
         fmt_tag_in   = '0;
         chans_in     = '0;
         rate_in      = '0;
         stride_in    = '0;
         bits_in      = '0;
         seen_fmt_in  = 1'b0;
         seen_data_in = 1'b0;
         fpos_in      = '0;
         fbytes_in    = '0;
         ext_v_in     = 1'b0;
         err_in       = ST_OK;
      end
   end

   // Queue entry for this byte.
   always_comb begin
      push                = accept && (main_v || stat_v);
      push_entry.main_v    = main_v;
      push_entry.main_info = main_info;
      push_entry.data      = main_data;
      push_entry.bps_m1    = 2'(bits_ff[5:3] - 3'd1);
      push_entry.is_float  = (fmt_tag_ff == FMT_TAG_FLOAT) && (bits_ff[5:3] == 3'd4);
      push_entry.stereo    = (chans_ff >= 16'd2);
      push_entry.stat_v    = stat_v;
      push_entry.status    = stat_code;
   end

   // Parser registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         phase_ff     <= PH_HEAD;
         tag_ff       <= '0;
         len_ff       <= '0;
         left_ff      <= '0;
         fmt_tag_ff   <= '0;
         chans_ff     <= '0;
         rate_ff      <= '0;
         stride_ff    <= '0;
         bits_ff      <= '0;
         seen_fmt_ff  <= 1'b0;
         seen_data_ff <= 1'b0;
         fpos_ff      <= '0;
         fbytes_ff    <= '0;
         ext_v_ff     <= 1'b0;
         ext_lo_ff    <= '0;
         err_ff       <= ST_OK;
      end else if (accept) begin
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         tag_ff       <= tag_in;
         len_ff       <= len_in;
         left_ff      <= left_in;
         fmt_tag_ff   <= fmt_tag_in;
         chans_ff     <= chans_in;
         rate_ff      <= rate_in;
         stride_ff    <= stride_in;
         bits_ff      <= bits_in;
         seen_fmt_ff  <= seen_fmt_in;
         seen_data_ff <= seen_data_in;
         fpos_ff      <= fpos_in;
         fbytes_ff    <= fbytes_in;
         ext_v_ff     <= ext_v_in;
         ext_lo_ff    <= ext_lo_in;
         err_ff       <= err_in;
      end
   end

`ifndef SYNTHESIS
   a_frame_needs_data: assert property (@(posedge clock) disable iff (reset)
      (push && push_entry.main_v && !push_entry.main_info) |-> (phase_ff == PH_DATA))
      else $error("frame queued outside a data chunk");
`endif

endmodule

`default_nettype wire

// ----- src/wsts_queue.sv -----
// ----------------------------------------------------------------------------
// wsts_queue: small queue between the parser and the decoder
// Register file with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module wsts_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire wsts_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     pop_valid,
   output wsts_pkg::entry_type      pop_entry
);
   import wsts_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] LIMIT = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_pop;

   assign full      = (cnt_ff == LIMIT);
   assign pop_valid = (cnt_ff != '0);
   assign pop_entry = mem_ff[rd_ff];
   assign do_pop    = pop && pop_valid;

   // Pointer and count update.
   always_comb begin
      wr_in  = push ? ((wr_ff == LAST) ? '0 : wr_ff + PTR_W'(1)) : wr_ff;
      rd_in  = do_pop ? ((rd_ff == LAST) ? '0 : rd_ff + PTR_W'(1)) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   a_count_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= LIMIT)
      else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// ----- src/wsts_back.sv -----
// ----------------------------------------------------------------------------
// wsts_back: sample decoder and result sequencer
// Turns queued frames into 16-bit samples in two stages and sends the frame or
// format info first and the status second.
// ----------------------------------------------------------------------------
`default_nettype none

module wsts_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   input  wire wsts_pkg::entry_type pop_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output wsts_pkg::rsp_type        rsp_data
);
   import wsts_pkg::*;

   // Integer PCM sample of one channel word.
   function automatic logic [15:0] int_sample(input logic [31:0] w, input logic [1:0] bps_m1);
      logic [15:0] s;
      case (bps_m1)
         2'd0:    s = {~w[7], w[6:0], 8'h00};
         2'd1:    s = w[15:0];
         2'd2:    s = w[23:8];
         default: s = w[31:16];
      endcase
      return s;
   endfunction

   // Finish a float sample from its word and the mantissa times 32767.
   function automatic logic [15:0] float_sample(input logic [31:0] w, input logic [38:0] q);
      logic [7:0]  e;
      logic        rnd;
      logic [24:0] hi;
      logic [40:0] al;
      logic [5:0]  sh;
      logic [15:0] mag;
      e   = w[30:23];
      rnd = 1'b0;
      hi  = '0;
      al  = '0;
      sh  = '0;
      mag = '0;
      if (e == 8'hFF && w[22:0] != 23'd0) begin
         mag = '0;
      end else if (e >= 8'd127) begin
         mag = 16'd32767;
      end else if (e < 8'd112) begin
         mag = '0;
      end else begin
         // Round the product to 24 significant bits, ties to even.
         if (q[38]) begin
            hi  = {1'b0, q[38:15]};
            rnd = q[14] && (q[13:0] != 14'd0 || q[15]);
            al  = ({16'b0, hi} + 41'(rnd)) << 15;
         end else begin
            hi  = q[38:14];
            rnd = q[13] && (q[12:0] != 13'd0 || q[14]);
            al  = ({16'b0, hi} + 41'(rnd)) << 14;
         end
         sh  = 6'(8'd150 - e);
         al  = al >> sh;
         mag = al[15:0];
      end
      return w[31] ? 16'(16'd0 - mag) : mag;
   endfunction

   logic        s1_v_ff, s1_v_in;
   entry_type   s1_e_ff;
   logic [31:0] s1_wl_ff, s1_wr_ff, word_l, word_r;
   logic [38:0] s1_ql_ff, s1_qr_ff, q_l, q_r;
   logic [2:0]  base;
   logic        s1_adv, out_free, rsp_take;
   logic [15:0] smp_l, smp_r;
   logic        main_v_ff, main_v_in, stat_v_ff, stat_v_in;
   rsp_type     main_ff, main_in;
   logic [3:0]  stat_ff;

   assign rsp_take = rsp_valid && !rsp_stall;
   assign out_free = (!main_v_ff && !stat_v_ff) || (rsp_take && !(main_v_ff && stat_v_ff));
   assign s1_adv   = !s1_v_ff || out_free;
   assign pop      = s1_adv && pop_valid;
   assign s1_v_in  = pop_valid;

   // Stage one: pick the channel words and multiply the float mantissas.
   always_comb begin
      base   = 3'(pop_entry.bps_m1) + 3'd1;
      word_l = pop_entry.data[31:0];
      word_r = pop_entry.data[{base, 3'b000} +: 32];
      q_l    = 39'({1'b1, word_l[22:0]} * 15'd32767);
      q_r    = 39'({1'b1, word_r[22:0]} * 15'd32767);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_e_ff  <= pop_entry;
         s1_wl_ff <= word_l;
         s1_wr_ff <= word_r;
         s1_ql_ff <= q_l;
         s1_qr_ff <= q_r;
      end
   end

   // Stage two: finish the samples and build the main result.
   always_comb begin
      smp_l = s1_e_ff.is_float ? float_sample(s1_wl_ff, s1_ql_ff)
                               : int_sample(s1_wl_ff, s1_e_ff.bps_m1);
      smp_r = !s1_e_ff.stereo ? smp_l :
              s1_e_ff.is_float ? float_sample(s1_wr_ff, s1_qr_ff)
                               : int_sample(s1_wr_ff, s1_e_ff.bps_m1);
      main_in = '0;
      if (s1_e_ff.main_info) begin
         main_in.kind    = KIND_INFO;
         main_in.rate_hz = s1_e_ff.data[31:0];
      end else begin
         main_in.kind  = KIND_FRAME;
         main_in.left  = smp_l;
         main_in.right = smp_r;
      end
   end

   // Output stage: the main result leaves before the status.
   always_comb begin
      main_v_in = main_v_ff;
      stat_v_in = stat_v_ff;
      if (s1_v_ff && out_free) begin
         main_v_in = s1_e_ff.main_v;
         stat_v_in = s1_e_ff.stat_v;
      end else if (rsp_take) begin
         if (main_v_ff) begin
            main_v_in = 1'b0;
         end else begin
            stat_v_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         stat_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         stat_v_ff <= stat_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff && out_free) begin
         main_ff <= main_in;
         stat_ff <= s1_e_ff.status;
      end
   end

   always_comb begin
      rsp_valid = main_v_ff || stat_v_ff;
      if (main_v_ff) begin
         rsp_data = main_ff;
      end else begin
         rsp_data        = '0;
         rsp_data.kind   = KIND_STATUS;
         rsp_data.status = stat_ff;
      end
   end

`ifndef SYNTHESIS
   a_main_first: assert property (@(posedge clock) disable iff (reset)
      main_v_ff |-> (rsp_data.kind != KIND_STATUS))
      else $error("status shown ahead of the main result");
   a_status_kept: assert property (@(posedge clock) disable iff (reset)
      (main_v_ff && stat_v_ff && rsp_take) |=> (stat_v_ff && !main_v_ff))
      else $error("status lost after the main result left");
`endif

endmodule

`default_nettype wire

// ----- src/wav_stream_to_stereo16.sv -----
// ----------------------------------------------------------------------------
// wav_stream_to_stereo16: RIFF/WAVE byte stream to 16-bit stereo frames
// Top level: parser, entry queue and sample decoder.
// ----------------------------------------------------------------------------
// Usage: file bytes enter on the req_ channel, one per transaction, with
// end_of_file set on the last byte. Results leave on the rsp_ channel: a
// format-info transaction when the data chunk starts, one frame transaction
// per complete frame, and one status transaction after the last byte.
// Throughput is one byte per cycle while the queue has room. A byte that
// yields both a frame or format info and the status needs two transactions,
// which the entry queue absorbs. From an accepted byte to its first result,
// the parser writes the queue, the decoder multiplies float mantissas in its
// first stage and rounds and shifts into the output register in its second.
// Reset returns the parser to the header phase and empties the queue and the
// output register. When the receiver stalls, results wait in the output
// register and the queue; req_stall rises only once the queue is full.
// After each status the parser is ready for the next file.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_stream_to_stereo16 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire wsts_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output wsts_pkg::rsp_type      rsp_data
);
   import wsts_pkg::*;

   entry_type push_entry, pop_entry;
   logic      push, q_full, pop, pop_valid;

   wsts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   wsts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   wsts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- test/wav_stream_to_stereo16_tb.sv -----
// ----------------------------------------------------------------------------
// wav_stream_to_stereo16_tb: self-checking bench for the WAVE stream parser
// Builds whole RIFF/WAVE files (valid, malformed, truncated and tiny), streams
// them byte by byte with random bursts and receiver stalls, and checks every
// result transaction against a behavioral parser kept inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_stream_to_stereo16_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wsts_pkg::*;

   // Parse phases of the behavioral parser.
   typedef enum logic [2:0] {
      PH_HEAD, PH_CHDR, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_HALT
   } phase_type;

   // One pending byte, or a marker that holds the sender until all results are in.
   typedef struct {
      logic [7:0] value;
      logic       last;
      bit         drain;
   } byte_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   wav_stream_to_stereo16 u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   byte_item_type byte_pending[$];
   rsp_type       wav_results_q[$];
   logic [7:0]    file_buf[$];
   int            error_count = 0;

   // Shadow parser state.
   logic [31:0] byte_cnt;
   phase_type   phase;
   logic [31:0] chunk_tag;
   logic [31:0] chunk_length;
   logic [31:0] chunk_left;
   logic [15:0] fmt_tag;
   logic [15:0] channel_count;
   logic [31:0] rate_value;
   logic [15:0] frame_stride;
   logic [15:0] sample_bits;
   logic        seen_fmt;
   logic        seen_data;
   logic [15:0] frame_pos;
   logic [63:0] frame_bytes;
   logic [3:0]  error_code;

   task automatic clear_parser();
      byte_cnt = '0;
      phase = PH_HEAD;
      chunk_tag = '0;
      chunk_length = '0;
      chunk_left = '0;
      fmt_tag = '0;
      channel_count = '0;
      rate_value = '0;
      frame_stride = '0;
      sample_bits = '0;
      seen_fmt = 1'b0;
      seen_data = 1'b0;
      frame_pos = '0;
      frame_bytes = '0;
      error_code = '0;
   endtask

   task automatic push_result(input logic [1:0] kind, input logic [15:0] l,
                              input logic [15:0] r, input logic [31:0] rate,
                              input logic [3:0] st);
      rsp_type e;
      e.kind = kind;
      e.left = l;
      e.right = r;
      e.rate_hz = rate;
      e.status = st;
      wav_results_q.push_back(e);
   endtask

   // Float sample to 16 bits: clamp, one single-precision rounding, truncate.
   function automatic logic [15:0] float_sample(input logic [31:0] u);
      logic [7:0]  e;
      logic [22:0] fr;
      logic [63:0] q, hi, rem, half;
      logic [31:0] mag;
      int          drop;
      e = u[30:23];
      fr = u[22:0];
      if (e == 8'hFF && fr != 0) return 16'h0000;
      if (e >= 8'd127) begin
         mag = 32'd32767;
      end else if (e < 8'd112) begin
         mag = 32'd0;
      end else begin
         q = {40'd0, 1'b1, fr} * 64'd32767;
         drop = (q >= (64'd1 << 38)) ? 15 : 14;
         hi = q >> drop;
         rem = q & ((64'd1 << drop) - 64'd1);
         half = 64'd1 << (drop - 1);
         if (rem > half || (rem == half && hi[0])) hi = hi + 64'd1;
         mag = 32'((hi << drop) >> (150 - int'(e)));
      end
      return u[31] ? 16'(32'd0 - mag) : mag[15:0];
   endfunction

   function automatic logic [15:0] sample_value(input int idx, input int bps,
                                                input bit is_float);
      logic [7:0] b[4];
      int         p;
      for (int k = 0; k < 4; k++) begin
         p = idx * bps + k;
         b[k] = (p < 8) ? frame_bytes[8*p +: 8] : 8'h00;
      end
      if (is_float) return float_sample({b[3], b[2], b[1], b[0]});
      case (bps)
         1: return {b[0] ^ 8'h80, 8'h00};
         2: return {b[1], b[0]};
         3: return {b[2], b[1]};
         4: return {b[3], b[2]};
         default: return 16'h0000;
      endcase
   endfunction

   task automatic end_body();
      chunk_left = '0;
      phase = chunk_length[0] ? PH_PAD : PH_CHDR;
   endtask

   task automatic skip_or_end();
      if (chunk_length == 0) begin
         end_body();
      end else begin
         chunk_left = chunk_length;
         phase = PH_SKIP;
      end
   endtask

   // Data chunk header done: validate the format in priority order.
   task automatic open_data();
      logic [31:0] need, align;
      logic [3:0]  err;
      need = {16'd0, sample_bits / 16'd8} * {16'd0, channel_count};
      align = {16'd0, frame_stride};
      err = ST_OK;
      seen_data = 1'b1;
      if (!seen_fmt) err = ST_NO_FMT;
      else if (fmt_tag != FMT_TAG_PCM && fmt_tag != FMT_TAG_FLOAT) err = ST_TAG;
      else if (channel_count == 0) err = ST_CHANNELS;
      else if (!(sample_bits inside {16'd8, 16'd16, 16'd24, 16'd32})) err = ST_BITS;
      else begin
         if (align == 0) align = need & 32'hFFFF;
         if (align < need) err = ST_ALIGN;
      end
      if (err != ST_OK) begin
         error_code = err;
         skip_or_end();
      end else begin
         frame_stride = align[15:0];
         frame_pos = '0;
         frame_bytes = '0;
         push_result(KIND_INFO, 16'h0, 16'h0, rate_value, ST_OK);
         if (chunk_length == 0) begin
            end_body();
         end else begin
            chunk_left = chunk_length;
            phase = PH_DATA;
         end
      end
   endtask

   function automatic logic [7:0] magic_byte(input int pos);
      case (pos)
         0: return "R";
         1: return "I";
         2: return "F";
         3: return "F";
         8: return "W";
         9: return "A";
         10: return "V";
         default: return "E";
      endcase
   endfunction

   // Expected results of one accepted file byte.
   task automatic predict_byte(input logic [7:0] b, input logic last);
      logic [31:0] pos, off, bw;
      logic [3:0]  st;
      logic [15:0] l, r;
      int          bps;
      bit          is_float;
      pos = byte_cnt;
      bw = {24'd0, b};
      if (byte_cnt != 32'hFFFF_FFFF) byte_cnt = byte_cnt + 1;
      case (phase)
         PH_HEAD: begin
            if (pos < 12 && (pos < 4 || pos >= 8) && b != magic_byte(int'(pos))) begin
               error_code = ST_BAD_MAGIC;
               phase = PH_HALT;
            end else if (pos >= 11) begin
               phase = PH_CHDR;
               chunk_left = '0;
            end
         end
         PH_CHDR: begin
            if (chunk_left < 4) begin
               chunk_tag = {b, chunk_tag[31:8]};
               if (chunk_left == 0) chunk_length = '0;
            end else begin
               chunk_length = chunk_length | (bw << (8 * ((chunk_left - 4) & 3)));
            end
            chunk_left = chunk_left + 1;
            if (chunk_left >= 8) begin
               chunk_left = '0;
               if (chunk_tag == TAG_FMT && chunk_length >= 16) begin
                  chunk_left = chunk_length;
                  frame_bytes = '0;
                  phase = PH_FMT;
               end else if (chunk_tag == TAG_DATA && !seen_data) begin
                  open_data();
               end else begin
                  skip_or_end();
               end
            end
         end
         PH_FMT: begin
            off = chunk_length - chunk_left;
            if (off < 2) fmt_tag[8*off +: 8] = b;
            else if (off < 4) channel_count[8*(off-2) +: 8] = b;
            else if (off < 8) rate_value[8*(off-4) +: 8] = b;
            else if (off == 12 || off == 13) frame_stride[8*(off-12) +: 8] = b;
            else if (off == 14 || off == 15) sample_bits[8*(off-14) +: 8] = b;
            else if (off == 24) begin
               if (fmt_tag == FMT_TAG_EXTENDED && chunk_length >= 40)
                  frame_bytes = 64'h100 | {56'd0, b};
            end else if (off == 25) begin
               if (frame_bytes[8]) fmt_tag = {b, frame_bytes[7:0]};
            end
            chunk_left = chunk_left - 1;
            if (chunk_left == 0) begin
               seen_fmt = 1'b1;
               frame_bytes = '0;
               end_body();
            end
         end
         PH_DATA: begin
            bps = int'(sample_bits / 16'd8);
            is_float = (fmt_tag == FMT_TAG_FLOAT && bps == 4);
            if (frame_pos < 8) frame_bytes[8*frame_pos +: 8] = b;
            frame_pos = frame_pos + 16'd1;
            if (frame_pos == frame_stride) begin
               l = sample_value(0, bps, is_float);
               r = (channel_count >= 2) ? sample_value(1, bps, is_float) : l;
               push_result(KIND_FRAME, l, r, 32'd0, ST_OK);
               frame_pos = '0;
               frame_bytes = '0;
            end
            chunk_left = chunk_left - 1;
            if (chunk_left == 0) begin
               frame_pos = '0;
               frame_bytes = '0;
               end_body();
            end
         end
         PH_SKIP: begin
            chunk_left = chunk_left - 1;
            if (chunk_left == 0) end_body();
         end
         PH_PAD: begin
            phase = PH_CHDR;
            chunk_left = '0;
         end
         default: ;
      endcase
      if (last) begin
         if (byte_cnt < MIN_FILE_BYTES) st = ST_TOO_SMALL;
         else if (error_code != ST_OK) st = error_code;
         else if (!seen_data) st = seen_fmt ? ST_NO_DATA : ST_NO_FMT;
         else if (phase == PH_DATA && chunk_left != 0) st = ST_TRUNCATED;
         else st = ST_OK;
         push_result(KIND_STATUS, 16'h0, 16'h0, 32'd0, st);
         clear_parser();
      end
   endtask

   // ------------------------------------------------------------------------
   // File construction.
   // ------------------------------------------------------------------------
   task automatic put8(input logic [7:0] v);
      file_buf.push_back(v);
   endtask

   task automatic put16(input logic [15:0] v);
      put8(v[7:0]);
      put8(v[15:8]);
   endtask

   task automatic put32(input logic [31:0] v);
      put16(v[15:0]);
      put16(v[31:16]);
   endtask

   // Float words: specials, values near the useful exponents, or any pattern.
   function automatic logic [31:0] float_word();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h3F80_0000;
            3: return 32'hBF80_0000;
            4: return 32'h7F80_0000;
            5: return 32'h7FC0_0000;
            6: return 32'hFF80_0001;
            7: return 32'h3F00_0000;
            8: return 32'h3800_0000;
            default: return 32'h37FF_FFFF;
         endcase
      end else if (sel < 7) begin
         return {1'($urandom), 8'($urandom_range(110, 128)), 23'($urandom)};
      end
      return $urandom;
   endfunction

   task automatic flush_file(input int cut);
      byte_item_type it;
      int n;
      n = (cut > 0 && cut < file_buf.size()) ? cut : file_buf.size();
      for (int i = 0; i < n; i++) begin
         it.value = file_buf[i];
         it.last = (i == n - 1);
         it.drain = 0;
         byte_pending.push_back(it);
      end
   endtask

   task automatic push_drain();
      byte_item_type it;
      it.value = '0;
      it.last = 1'b0;
      it.drain = 1;
      byte_pending.push_back(it);
   endtask

   // Modes: 0 normal, 1 tiny, 2 bad magic, 3 no fmt chunk, 4 ends inside data.
   task automatic build_file(input int mode);
      int          ch, bits, flen, nfr, dlen, stride, jlen, sel, cut;
      logic [15:0] tag, real_tag, align;
      logic [31:0] word, declared;
      bit          ext, is_float;
      int          idx;
      file_buf.delete();
      put32(32'h4646_4952);
      put32($urandom);
      put32(32'h4556_4157);
      if (mode == 2) begin
         idx = $urandom_range(0, 7);
         if (idx >= 4) idx = idx + 4;
         file_buf[idx] = file_buf[idx] ^ (8'd1 << $urandom_range(0, 7));
      end
      // Optional unknown chunk ahead of fmt, odd lengths padded.
      if ($urandom_range(0, 3) == 0) begin
         jlen = $urandom_range(0, 5);
         put32(32'h5453_494C);
         put32(jlen);
         for (int i = 0; i < jlen; i++) put8(8'($urandom));
         if (jlen % 2) put8(8'($urandom));
      end
      sel = $urandom_range(0, 9);
      ch = (sel < 1) ? 0 : (sel < 5) ? 1 : (sel < 9) ? 2 : $urandom_range(3, 6);
      sel = $urandom_range(0, 15);
      bits = (sel == 0) ? $urandom_range(0, 40) : 8 * $urandom_range(1, 4);
      sel = $urandom_range(0, 11);
      ext = 0;
      real_tag = FMT_TAG_PCM;
      if (sel < 5) tag = FMT_TAG_PCM;
      else if (sel < 8) tag = FMT_TAG_FLOAT;
      else if (sel < 11) begin
         tag = FMT_TAG_EXTENDED;
         ext = 1;
         real_tag = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                    ($urandom_range(0, 1) ? FMT_TAG_FLOAT : FMT_TAG_PCM);
      end else tag = 16'($urandom);
      if (ext) flen = ($urandom_range(0, 4) == 0) ? 22 : 40;
      else begin
         sel = $urandom_range(0, 9);
         flen = (sel < 6) ? 16 : (sel < 8) ? 18 : (sel < 9) ? 17 : 14;
      end
      stride = (bits / 8) * ch;
      sel = $urandom_range(0, 9);
      if (sel < 5) align = 16'(stride);
      else if (sel < 7) align = 0;
      else if (sel < 9) align = 16'(stride + $urandom_range(1, 3));
      else align = 16'($urandom_range(0, 12));
      if (mode != 3) begin
         put32(TAG_FMT);
         put32(flen);
         put16(tag);
         put16(16'(ch));
         put32($urandom);
         put32($urandom);
         put16(align);
         put16(16'(bits));
         for (int i = 16; i < flen; i++) begin
            if (i == 24) put8(real_tag[7:0]);
            else if (i == 25) put8(real_tag[15:8]);
            else put8(8'($urandom));
         end
         if (flen % 2) put8(8'($urandom));
      end
      // Data chunk; small frame counts keep the files short.
      if (align != 0) stride = int'(align);
      if (stride == 0 || stride > 32) dlen = $urandom_range(0, 40);
      else begin
         nfr = $urandom_range(0, 7);
         dlen = nfr * stride + $urandom_range(0, 2);
      end
      is_float = (tag == FMT_TAG_FLOAT || (ext && real_tag == FMT_TAG_FLOAT)) && bits == 32;
      declared = dlen;
      if (mode == 4) declared = dlen + 1 + ($urandom_range(0, 1) ? $urandom : 5);
      put32(TAG_DATA);
      put32(declared);
      for (int i = 0; i < dlen; i++) begin
         if (i % 4 == 0) word = is_float ? float_word() : $urandom;
         put8(word[8*(i%4) +: 8]);
      end
      if (mode != 4) begin
         if (dlen % 2) put8(8'($urandom));
         // Sometimes a second data chunk or an unknown chunk, both only skipped.
         if ($urandom_range(0, 4) == 0) begin
            jlen = $urandom_range(0, 6);
            put32($urandom_range(0, 1) ? TAG_DATA : 32'h7473_6166);
            put32(jlen);
            for (int i = 0; i < jlen; i++) put8(8'($urandom));
            if (jlen % 2) put8(8'($urandom));
         end
      end
      cut = 0;
      if (mode == 1) cut = $urandom_range(1, 43);
      else if (mode == 0 && $urandom_range(0, 9) == 0)
         cut = $urandom_range(1, file_buf.size());
      flush_file(cut);
   endtask

   // ------------------------------------------------------------------------
   // Sender: bursts of random length with random gaps.
   // ------------------------------------------------------------------------
   int            burst_left = 0;
   int            gap_left = 0;
   byte_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_byte(req_data.byte_in, req_data.end_of_file);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (byte_pending.size() != 0 && byte_pending[0].drain) begin
               req_valid <= 1'b0;
               if (wav_results_q.size() == 0) void'(byte_pending.pop_front());
            end else if (byte_pending.size() != 0) begin
               next_item = byte_pending.pop_front();
               req_valid <= 1'b1;
               req_data <= '{byte_in: next_item.value, end_of_file: next_item.last};
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) :
                               $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall patterns, one long hold-off, and result checking.
   // ------------------------------------------------------------------------
   int cycle_cnt = 0;
   int hold_left = 0;
   int stall_mode = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycle_cnt++;
         if (rsp_valid && !rsp_stall) begin
            if (wav_results_q.size() == 0) begin
               report_mismatch("unexpected transaction", 32'(rsp_data.kind), 32'd0);
            end else begin
               want = wav_results_q.pop_front();
               if (rsp_data.kind != want.kind)
                  report_mismatch("kind", 32'(rsp_data.kind), 32'(want.kind));
               if (rsp_data.left != want.left)
                  report_mismatch("left", 32'(rsp_data.left), 32'(want.left));
               if (rsp_data.right != want.right)
                  report_mismatch("right", 32'(rsp_data.right), 32'(want.right));
               if (rsp_data.rate_hz != want.rate_hz)
                  report_mismatch("rate_hz", rsp_data.rate_hz, want.rate_hz);
               if (rsp_data.status != want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            end
         end
         if (cycle_cnt == 500) hold_left = 600;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (cycle_cnt % 97 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ((cycle_cnt % 5) < 3);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------------
   initial begin
      int sel;
      clear_parser();
      // Directed files: tiny, bad magic, missing fmt, truncated, then normal.
      build_file(1);
      build_file(2);
      build_file(3);
      build_file(4);
      build_file(0);
      push_drain();
      while (byte_pending.size() < 1850) begin
         sel = $urandom_range(0, 19);
         build_file(sel < 14 ? 0 : sel < 16 ? 4 : sel < 17 ? 1 : sel < 18 ? 2 : 3);
         if ($urandom_range(0, 15) == 0) push_drain();
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (byte_pending.size() != 0 || req_valid) @(posedge clock);
      while (wav_results_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
src/wsts_pkg.sv
src/wsts_front.sv
src/wsts_queue.sv
src/wsts_back.sv
src/wav_stream_to_stereo16.sv
test/wav_stream_to_stereo16_tb.sv
